FILE: src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/psqs_pkg.sv
// Package: constants, register codes and the pattern function of the pulse sniffer.
package psqs_pkg;

    // Quantiser constants
    localparam int unsigned SYMBOL_UNIT  = 100;
    localparam int unsigned SYMBOL_HALF  = 50;
    localparam int unsigned DURATION_CAP = 255 * SYMBOL_UNIT;
    localparam int unsigned DUR_W        = 16;
    localparam int unsigned SYM_W        = 8;
    localparam int unsigned CAP_W        = $clog2(DURATION_CAP + SYMBOL_HALF + 1);
    // floor(x / 100) as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 25551
    localparam int unsigned RECIP_SHIFT  = 19;
    localparam int unsigned RECIP_MUL    = ((1 << RECIP_SHIFT) + SYMBOL_UNIT - 1) / SYMBOL_UNIT;
    localparam int unsigned RECIP_W      = $clog2(RECIP_MUL + 1);

    // Activity window defaults
    localparam int ACTIVITY_WINDOW_DEF    = 8;
    localparam int ACTIVITY_LAG_DEPTH_DEF = 10;

    // Configuration register layout
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MIN_W      = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_SELECT  = 2'd0,
        CFG_RANGE_FLOOR    = 2'd1,
        CFG_RANGE_CEILING  = 2'd2,
        CFG_ACTIVE_MINIMUM = 2'd3
    } cfg_index_t;

    localparam logic             STREAM_SELECT_RST  = 1'b1;
    localparam logic [DUR_W-1:0] RANGE_FLOOR_RST    = 16'd200;
    localparam logic [DUR_W-1:0] RANGE_CEILING_RST  = 16'd5000;
    localparam logic [MIN_W-1:0] ACTIVE_MINIMUM_RST = 5'd12;

    // Repeat-pattern check on a four-symbol window, p0 oldest; first rule wins
    function automatic logic [SYM_W-1:0] pattern_of(
        input logic [SYM_W-1:0] p0,
        input logic [SYM_W-1:0] p1,
        input logic [SYM_W-1:0] p2,
        input logic [SYM_W-1:0] p3
    );
        logic [SYM_W-1:0] res;
        res = '0;
        if (p0 == '0 || p1 == '0 || p2 == '0 || p3 == '0) begin
            res = '0;
        end else if (p0 == p1 && p1 == p2 && p2 == p3) begin
            res = p0;
        end else if (p0 == p1 && p2 == p3) begin
            res = (p0 < p2) ? p0 : p2;
        end else if (p0 == p3 && p1 == p2) begin
            res = p0;
        end else if (p0 == p2 && p1 == p3) begin
            res = p0;
        end else if ((p0 == p1 && p1 == p2) || (p0 == p1 && p1 == p3)
                     || (p0 == p2 && p2 == p3)) begin
            res = p0;
        end else if (p1 == p2 && p2 == p3) begin
            res = p1;
        end
        return res;
    endfunction

endpackage

FILE: src/psqs_cell.sv
// Shift cell: holds one entry of a chain and takes its neighbour's entry on each beat.
module psqs_cell #(
    parameter int WIDTH = psqs_pkg::SYM_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] d_in,
    output logic [WIDTH-1:0] q_out
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // Take the neighbour's value when the chain advances
    always_comb begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign q_out = data_reg;

endmodule

FILE: src/psqs_quant.sv
// Quantiser: saturates a duration and rounds it to hundreds of microseconds.
module psqs_quant (
    input  logic [psqs_pkg::DUR_W-1:0] dur_us,
    output logic [psqs_pkg::SYM_W-1:0] symbol
);

    localparam int unsigned PROD_W = psqs_pkg::CAP_W + psqs_pkg::RECIP_W;

    logic [psqs_pkg::CAP_W-1:0] capped;
    logic [psqs_pkg::CAP_W-1:0] biased;
    logic [PROD_W-1:0]          prod;

    // Saturate, add half a unit, then divide by the unit via its reciprocal
    always_comb begin
        if (dur_us > psqs_pkg::DUR_W'(psqs_pkg::DURATION_CAP)) begin
            capped = psqs_pkg::CAP_W'(psqs_pkg::DURATION_CAP);
        end else begin
            capped = dur_us[psqs_pkg::CAP_W-1:0];
        end
        biased = capped + psqs_pkg::CAP_W'(psqs_pkg::SYMBOL_HALF);
        prod   = PROD_W'(biased) * PROD_W'(psqs_pkg::RECIP_MUL);
        symbol = prod[psqs_pkg::RECIP_SHIFT +: psqs_pkg::SYM_W];
    end

endmodule

FILE: src/pulse_symbol_quantizer_sniffer.sv
// Top level: pulse-pair quantiser with repeat-pattern window and activity detector.
// Takes one low/high duration pair per beat and returns one result per pair in the
// cycle after acceptance; a new pair is taken every cycle as long as the result
// register is empty or being emptied in the same cycle, so the sustained rate is one
// pair per clock, set by the single output register. Symbols of the selected stream
// shift through a four-cell chain that feeds the pattern check; in-range flags shift
// through an ACTIVITY_LAG_DEPTH-cell chain, and a running count adds the flag entering
// the counted span and drops the one leaving it. Configuration writes are always taken.
module pulse_symbol_quantizer_sniffer #(
    parameter int ACTIVITY_WINDOW    = psqs_pkg::ACTIVITY_WINDOW_DEF,
    parameter int ACTIVITY_LAG_DEPTH = psqs_pkg::ACTIVITY_LAG_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input pairs
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [psqs_pkg::DUR_W-1:0]      s_low_us,
    input  logic [psqs_pkg::DUR_W-1:0]      s_high_us,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [psqs_pkg::SYM_W-1:0]      m_low_symbol,
    output logic [psqs_pkg::SYM_W-1:0]      m_high_symbol,
    output logic [psqs_pkg::SYM_W-1:0]      m_pattern_symbol,
    output logic                            m_receiving,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psqs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH   = ACTIVITY_LAG_DEPTH;
    localparam int FIRST   = (DEPTH > ACTIVITY_WINDOW) ? DEPTH - ACTIVITY_WINDOW : 0;
    localparam int WIN_LEN = DEPTH - FIRST;
    localparam int CNT_W   = $clog2(2 * WIN_LEN + 1);
    localparam int CMP_W   = (CNT_W > psqs_pkg::MIN_W) ? CNT_W : psqs_pkg::MIN_W;
    localparam int SYM_W   = psqs_pkg::SYM_W;
    localparam int WIN_N   = 4;

    // Configuration registers
    logic                          stream_select_reg;
    logic [psqs_pkg::DUR_W-1:0]    range_floor_reg;
    logic [psqs_pkg::DUR_W-1:0]    range_ceiling_reg;
    logic [psqs_pkg::MIN_W-1:0]    active_minimum_reg;

    // Result register
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [SYM_W-1:0]              m_low_symbol_reg;
    logic [SYM_W-1:0]              m_high_symbol_reg;
    logic                          m_receiving_reg;
    logic                          m_receiving_next;

    logic                          accept;
    logic [SYM_W-1:0]              low_sym;
    logic [SYM_W-1:0]              high_sym;
    logic [SYM_W-1:0]              sym_new;
    logic [SYM_W-1:0]              sym_q [WIN_N];
    logic [1:0]                    flag_new;
    logic [1:0]                    flag_q [DEPTH];
    logic [1:0]                    flag_enter;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_select_reg  <= psqs_pkg::STREAM_SELECT_RST;
            range_floor_reg    <= psqs_pkg::RANGE_FLOOR_RST;
            range_ceiling_reg  <= psqs_pkg::RANGE_CEILING_RST;
            active_minimum_reg <= psqs_pkg::ACTIVE_MINIMUM_RST;
        end else if (cfg_valid) begin
            unique case (psqs_pkg::cfg_index_t'(cfg_index))
                psqs_pkg::CFG_STREAM_SELECT:  stream_select_reg  <= cfg_data[0];
                psqs_pkg::CFG_RANGE_FLOOR:    range_floor_reg    <= cfg_data;
                psqs_pkg::CFG_RANGE_CEILING:  range_ceiling_reg  <= cfg_data;
                psqs_pkg::CFG_ACTIVE_MINIMUM: active_minimum_reg <= cfg_data[psqs_pkg::MIN_W-1:0];
            endcase
        end
    end

    // Quantise both durations
    psqs_quant u_quant_low  (.dur_us(s_low_us),  .symbol(low_sym));
    psqs_quant u_quant_high (.dur_us(s_high_us), .symbol(high_sym));

    assign sym_new = stream_select_reg ? low_sym : high_sym;

    // Symbol window chain, cell 0 newest
    genvar gi;
    generate
        for (gi = 0; gi < WIN_N; gi++) begin : g_sym
            psqs_cell #(.WIDTH(SYM_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .d_in     ((gi == 0) ? sym_new : sym_q[(gi == 0) ? 0 : gi - 1]),
                .q_out    (sym_q[gi])
            );
        end
    endgenerate

    // Range flags of the arriving pair
    assign flag_new[0] = (range_floor_reg < s_low_us)  && (s_low_us  < range_ceiling_reg);
    assign flag_new[1] = (range_floor_reg < s_high_us) && (s_high_us < range_ceiling_reg);

    // Activity flag chain, cell 0 newest
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_flag
            psqs_cell #(.WIDTH(2)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .d_in     ((gi == 0) ? flag_new : flag_q[(gi == 0) ? 0 : gi - 1]),
                .q_out    (flag_q[gi])
            );
        end
        // Flag that moves into the first counted cell on a beat
        if (FIRST == 0) begin : g_enter_new
            assign flag_enter = flag_new;
        end else begin : g_enter_chain
            assign flag_enter = flag_q[FIRST-1];
        end
    endgenerate

    // Running count over the counted span: add the entering flag, drop the leaving one
    always_comb begin
        count_next = count_reg
                   + CNT_W'(flag_enter[0]) + CNT_W'(flag_enter[1])
                   - CNT_W'(flag_q[DEPTH-1][0]) - CNT_W'(flag_q[DEPTH-1][1]);
        m_receiving_next = (CMP_W'(count_next) >= CMP_W'(active_minimum_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    // Result register: load on accept, drop on take
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_low_symbol_reg  <= low_sym;
            m_high_symbol_reg <= high_sym;
            m_receiving_reg   <= m_receiving_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_low_symbol     = m_low_symbol_reg;
    assign m_high_symbol    = m_high_symbol_reg;
    assign m_receiving      = m_receiving_reg;
    // The window only moves together with the result register, so it holds while stalled
    assign m_pattern_symbol = psqs_pkg::pattern_of(sym_q[3], sym_q[2], sym_q[1], sym_q[0]);

endmodule

FILE: src/psqs_checker.sv
// Checker: port-level assertions on the pulse sniffer, bound to the top level.
`include "assert_macros.svh"

module psqs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [psqs_pkg::SYM_W-1:0] m_low_symbol,
    input logic [psqs_pkg::SYM_W-1:0] m_high_symbol,
    input logic [psqs_pkg::SYM_W-1:0] m_pattern_symbol
);

    property p_hold_stalled;
        m_valid && !m_ready |=> m_valid && $stable(m_low_symbol) && $stable(m_high_symbol)
            && $stable(m_pattern_symbol);
    endproperty

    property p_result_follows;
        s_valid && s_ready |=> m_valid;
    endproperty

    property p_ready_when_empty;
        !m_valid |-> s_ready;
    endproperty

    property p_pattern_nonzero;
        m_valid && m_pattern_symbol != 0 |-> m_low_symbol != 0 || m_high_symbol != 0;
    endproperty

    // A stalled result keeps its beat
    `ASSERT_CLK(a_hold_stalled, aclk, aresetn, p_hold_stalled, "stalled result changed")

    // Every accepted pair shows a result on the next cycle
    `ASSERT_CLK(a_result_follows, aclk, aresetn, p_result_follows, "accepted pair gave no result")

    // An empty result register never blocks the input
    `ASSERT_ALWAYS(a_ready_when_empty, aclk, p_ready_when_empty, "input blocked, nothing pending")

    // A found pattern means the result's low or high symbol is non-zero
    `ASSERT_CLK(a_pattern_nonzero, aclk, aresetn, p_pattern_nonzero, "pattern with zero symbol")

endmodule

bind pulse_symbol_quantizer_sniffer psqs_checker u_psqs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_low_symbol     (m_low_symbol),
    .m_high_symbol    (m_high_symbol),
    .m_pattern_symbol (m_pattern_symbol)
);

FILE: tb/sv/psqs_result_checker.sv
`timescale 1ns / 1ps
// Checker for the pulse sniffer: watches all three channels, predicts each result and compares it.
module psqs_result_checker
    import psqs_pkg::*;
#(
    parameter int ACTIVITY_WINDOW    = ACTIVITY_WINDOW_DEF,
    parameter int ACTIVITY_LAG_DEPTH = ACTIVITY_LAG_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [DUR_W-1:0]      s_low_us,
    input  logic [DUR_W-1:0]      s_high_us,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SYM_W-1:0]      m_low_symbol,
    input  logic [SYM_W-1:0]      m_high_symbol,
    input  logic [SYM_W-1:0]      m_pattern_symbol,
    input  logic                  m_receiving,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           error_count,
    output int unsigned           pending_count,
    output int unsigned           checked_count,
    output int unsigned           pattern_count,
    output int unsigned           receiving_count
);

    typedef struct packed {
        logic [SYM_W-1:0] low_symbol;
        logic [SYM_W-1:0] high_symbol;
        logic [SYM_W-1:0] pattern_symbol;
        logic             receiving;
    } sniff_result_t;

    // Register copies, as last written through the configuration channel
    logic             window_takes_low;
    logic [DUR_W-1:0] band_floor_us;
    logic [DUR_W-1:0] band_ceiling_us;
    logic [MIN_W-1:0] hits_needed;

    // Sniffer state: newest symbol at index 3, newest band flags at index 0
    logic [SYM_W-1:0] recent_symbols [4];
    logic [1:0]       band_hits [ACTIVITY_LAG_DEPTH];

    sniff_result_t expected_results [$];
    int unsigned   mismatches;
    int unsigned   results_checked;
    int unsigned   patterns_found;
    int unsigned   receiving_found;

    // Saturate at 255 units and round half up to whole units
    function automatic logic [SYM_W-1:0] to_symbol(input logic [DUR_W-1:0] us);
        int unsigned capped;
        capped = (us > DURATION_CAP) ? DURATION_CAP : us;
        return SYM_W'((capped + SYMBOL_HALF) / SYMBOL_UNIT);
    endfunction

    // Repeat-pattern lookup on oldest-first symbols a..d; earlier rules take priority
    function automatic logic [SYM_W-1:0] repeat_symbol(
        input logic [SYM_W-1:0] a,
        input logic [SYM_W-1:0] b,
        input logic [SYM_W-1:0] c,
        input logic [SYM_W-1:0] d
    );
        if (a == 0 || b == 0 || c == 0 || d == 0)
            return '0;
        if (a == b && b == c && c == d)
            return a;
        if (a == b && c == d)
            return (a < c) ? a : c;
        if ((a == d && b == c) || (a == c && b == d))
            return a;
        if ((a == b && (b == c || b == d)) || (a == c && c == d))
            return a;
        if (b == c && c == d)
            return b;
        return '0;
    endfunction

    function automatic logic in_band(input logic [DUR_W-1:0] us);
        return (band_floor_us < us) && (us < band_ceiling_us);
    endfunction

    // Advance the sniffer state by one pair and form its result
    task automatic sniff_pair(
        input  logic [DUR_W-1:0] low_us,
        input  logic [DUR_W-1:0] high_us,
        output sniff_result_t    res
    );
        int          i;
        int          first;
        int unsigned hits;
        res.low_symbol  = to_symbol(low_us);
        res.high_symbol = to_symbol(high_us);
        for (i = 0; i < 3; i++)
            recent_symbols[i] = recent_symbols[i + 1];
        recent_symbols[3] = window_takes_low ? res.low_symbol : res.high_symbol;
        res.pattern_symbol = repeat_symbol(recent_symbols[0], recent_symbols[1],
                                           recent_symbols[2], recent_symbols[3]);
        for (i = ACTIVITY_LAG_DEPTH - 1; i > 0; i--)
            band_hits[i] = band_hits[i - 1];
        band_hits[0] = {in_band(high_us), in_band(low_us)};
        // count only the lagging span of the flag chain
        first = ACTIVITY_LAG_DEPTH - ACTIVITY_WINDOW;
        if (first < 0)
            first = 0;
        hits = 0;
        for (i = first; i < ACTIVITY_LAG_DEPTH; i++)
            hits += band_hits[i][0] + band_hits[i][1];
        res.receiving = (hits >= hits_needed);
    endtask

    task automatic compare_field(input string field, input int unsigned want, got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        sniff_result_t predicted;
        sniff_result_t oldest;
        if (!aresetn) begin
            window_takes_low = STREAM_SELECT_RST;
            band_floor_us    = RANGE_FLOOR_RST;
            band_ceiling_us  = RANGE_CEILING_RST;
            hits_needed      = ACTIVE_MINIMUM_RST;
            foreach (recent_symbols[i])
                recent_symbols[i] = '0;
            foreach (band_hits[i])
                band_hits[i] = '0;
            expected_results.delete();
            mismatches      = 0;
            results_checked = 0;
            patterns_found  = 0;
            receiving_found = 0;
        end else begin
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STREAM_SELECT:  window_takes_low = cfg_data[0];
                    CFG_RANGE_FLOOR:    band_floor_us    = cfg_data;
                    CFG_RANGE_CEILING:  band_ceiling_us  = cfg_data;
                    CFG_ACTIVE_MINIMUM: hits_needed      = cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
            // Predict each accepted pair
            if (s_valid && s_ready) begin
                sniff_pair(s_low_us, s_high_us, predicted);
                expected_results.push_back(predicted);
            end
            // Compare each result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d",
                             $time, m_low_symbol, m_high_symbol, m_pattern_symbol,
                             m_receiving);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    compare_field("low_symbol", oldest.low_symbol, m_low_symbol);
                    compare_field("high_symbol", oldest.high_symbol, m_high_symbol);
                    compare_field("pattern_symbol", oldest.pattern_symbol, m_pattern_symbol);
                    compare_field("receiving", oldest.receiving, m_receiving);
                    results_checked++;
                    if (oldest.pattern_symbol != 0)
                        patterns_found++;
                    if (oldest.receiving)
                        receiving_found++;
                end
            end
        end
        error_count     <= mismatches;
        pending_count   <= expected_results.size();
        checked_count   <= results_checked;
        pattern_count   <= patterns_found;
        receiving_count <= receiving_found;
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the pulse sniffer: stimulus, flow control, register phases and verdict.
module tb;
    import psqs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [DUR_W-1:0]      s_low_us;
    logic [DUR_W-1:0]      s_high_us;
    logic                  m_valid;
    logic                  m_ready;
    logic [SYM_W-1:0]      m_low_symbol;
    logic [SYM_W-1:0]      m_high_symbol;
    logic [SYM_W-1:0]      m_pattern_symbol;
    logic                  m_receiving;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned pattern_count;
    int unsigned receiving_count;

    int unsigned cycle_count;
    int unsigned pairs_sent;
    int unsigned settings_used;
    int unsigned hold_off_cycles;
    logic        send_idling;
    logic        ready_idling;
    logic [DUR_W-1:0] cur_floor;
    logic [DUR_W-1:0] cur_ceiling;
    int unsigned symbol_base;
    int unsigned run_left;
    logic        run_patterned;

    pulse_symbol_quantizer_sniffer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_low_us         (s_low_us),
        .s_high_us        (s_high_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_low_symbol     (m_low_symbol),
        .m_high_symbol    (m_high_symbol),
        .m_pattern_symbol (m_pattern_symbol),
        .m_receiving      (m_receiving),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    psqs_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_low_us         (s_low_us),
        .s_high_us        (s_high_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_low_symbol     (m_low_symbol),
        .m_high_symbol    (m_high_symbol),
        .m_pattern_symbol (m_pattern_symbol),
        .m_receiving      (m_receiving),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .pending_count    (pending_count),
        .checked_count    (checked_count),
        .pattern_count    (pattern_count),
        .receiving_count  (receiving_count)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Cycle counter and timeout
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results still awaited",
                 $time, CYCLE_LIMIT, pending_count);
        $display("status: fail");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (ready_idling && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one pair, with an optional idle burst ahead of it; return at its accepting edge
    task automatic send_pair(input logic [DUR_W-1:0] low_us, input logic [DUR_W-1:0] high_us);
        if (send_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_low_us  <= low_us;
        s_high_us <= high_us;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pairs_sent++;
    endtask

    // Hold valid high across back-to-back writes; the caller drops it afterwards
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic take_low, input logic [DUR_W-1:0] floor_us,
                              input logic [DUR_W-1:0] ceiling_us, input int unsigned needed);
        write_reg(CFG_STREAM_SELECT, CFG_DATA_W'(take_low));
        write_reg(CFG_RANGE_FLOOR, floor_us);
        write_reg(CFG_RANGE_CEILING, ceiling_us);
        write_reg(CFG_ACTIVE_MINIMUM, CFG_DATA_W'(needed));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_floor   = floor_us;
        cur_ceiling = ceiling_us;
        settings_used++;
    endtask

    // Drop valid, then wait until every predicted result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Duration whose symbol is base or base + 1, anywhere inside the rounding span
    function automatic logic [DUR_W-1:0] patterned_us();
        int unsigned v;
        v = (symbol_base + $urandom_range(0, 1)) * SYMBOL_UNIT - SYMBOL_HALF
            + $urandom_range(0, SYMBOL_UNIT - 1);
        return (v > 65535) ? 16'hFFFF : DUR_W'(v);
    endfunction

    // Noise: full-scale values, band edges and the saturation corner
    function automatic logic [DUR_W-1:0] noise_us();
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = $urandom_range(0, 65535);
        else if (sel < 6)
            v = int'(cur_floor) + $urandom_range(0, 2) - 1;
        else if (sel < 8)
            v = int'(cur_ceiling) + $urandom_range(0, 2) - 1;
        else if (sel == 8)
            v = $urandom_range(DURATION_CAP - 100, DURATION_CAP + 100);
        else
            v = 65535 - $urandom_range(0, 1);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return DUR_W'(v);
    endfunction

    // Mostly runs of repeating symbols, broken up by runs of noise
    task automatic run_random(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if (run_left == 0) begin
                run_left      = $urandom_range(4, 12);
                run_patterned = ($urandom_range(0, 3) != 0);
                symbol_base   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 254)
                                                            : $urandom_range(1, 50);
            end
            run_left--;
            if (run_patterned)
                send_pair(patterned_us(), patterned_us());
            else
                send_pair(noise_us(), noise_us());
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [DUR_W-1:0] directed_low [$];
        logic [DUR_W-1:0] directed_high [$];
        int unsigned      i;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_low_us        = '0;
        s_high_us       = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_STREAM_SELECT;
        cfg_data        = '0;
        pairs_sent      = 0;
        settings_used   = 1;
        hold_off_cycles = 0;
        send_idling     = 1'b1;
        ready_idling    = 1'b1;
        cur_floor       = RANGE_FLOOR_RST;
        cur_ceiling     = RANGE_CEILING_RST;
        symbol_base     = 1;
        run_left        = 0;
        run_patterned   = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rounding and saturation corners, band edges, then each repeat shape
        directed_low  = '{0, 49, 50, 149, 25449, 25549, 65535, 200, 4999,
                          300, 300, 300, 300, 500, 500, 200, 200,
                          400, 700, 700, 400, 600, 900, 600, 900};
        directed_high = '{65535, 50, 49, 150, 25450, 25551, 0, 201, 5000,
                          2500, 2500, 2500, 2500, 2500, 2500, 2500, 2500,
                          2500, 2500, 2500, 2500, 2500, 2500, 2500, 2500};
        for (i = 0; i < directed_low.size(); i++)
            send_pair(directed_low[i], directed_high[i]);

        // Defaults with idling, then a long receiver hold-off while the sender keeps going
        run_random(60);
        hold_off_cycles = 300;
        send_idling = 1'b0;
        run_random(40);
        send_idling = 1'b1;
        run_random(50);
        drain();

        // High stream, widest band, largest minimum
        set_config(1'b0, 16'd0, 16'hFFFF, 16);
        run_random(80);
        drain();

        // Inverted band, minimum of zero
        set_config(1'b1, 16'hFFFF, 16'd0, 0);
        run_random(60);
        drain();

        // Band with no room inside it
        set_config(1'b0, 16'd1000, 16'd1001, 1);
        run_random(50);
        drain();

        // Random settings
        repeat (2) begin
            set_config(1'($urandom_range(0, 1)), DUR_W'($urandom_range(0, 3000)),
                       DUR_W'($urandom_range(1000, 8000)), $urandom_range(0, 16));
            run_random(50);
            drain();
        end

        // Back to defaults, no idling on either side
        set_config(STREAM_SELECT_RST, RANGE_FLOOR_RST, RANGE_CEILING_RST,
                   32'(ACTIVE_MINIMUM_RST));
        send_idling  = 1'b0;
        ready_idling = 1'b0;
        run_random(110);
        drain();

        $display("Sent %0d pulse pairs under %0d register settings; %0d results checked.",
                 pairs_sent, settings_used, checked_count);
        $display("Results with a repeat symbol: %0d, with receiving set: %0d.",
                 pattern_count, receiving_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/psqs_pkg.sv
src/psqs_cell.sv
src/psqs_quant.sv
src/pulse_symbol_quantizer_sniffer.sv
src/psqs_checker.sv
tb/sv/psqs_result_checker.sv
tb/sv/tb.sv
